/* sv/trpg_pkg.sv */
`default_nettype none
package trpg_pkg;

  localparam int RingDepthDef = 64;

  // configuration register indexes
  localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_RING_ENTRIES = 2'd1;

  localparam logic [30:0] LINE_WIDTH_RST   = 31'd65536;
  localparam logic [6:0]  RING_ENTRIES_RST = 7'd64;

  // thresholds: 0.01 and 0.0025 in Q32.32, 0.99 in Q.30
  localparam logic [63:0]        FWD_MIN_SQ  = 64'd42949673;
  localparam logic [33:0]        CLOSE_SQ    = 34'd10737419;
  localparam logic signed [35:0] DOT_PAR_MIN = 36'sd1063004406;

  typedef enum logic [1:0] {
    ST_APPEND = 2'd0,
    ST_CLOSE  = 2'd1,
    ST_NOPT   = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_M, S_SQ_W, S_CHK_S, S_R1, S_N_M, S_N_W, S_DOT_M, S_DOT_W,
    S_CHK_DOT, S_CR_M, S_CR_W, S_S2_M, S_S2_W, S_R2_GO, S_R2, S_U_M, S_U_W,
    S_PP_M, S_PP_W, S_PAR, S_TB, S_CL_M, S_CL_W, S_CL_CHK, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    RS_IDLE, RS_DIV, RS_SQRT, RS_DONE
  } rsq_state_e;

endpackage
`default_nettype wire

/* sv/trail_ribbon_point_generator_unit.sv */
// a motion that is too short ends after its squared length check; a full ribbon
//   point runs two reciprocal square roots (65 divide steps plus 33 root steps
//   each) and 27 passes through the shared 33x33 multiplier
// throughput: one word at a time, the next word is taken once the result is loaded
// reset: async active low, trail empty, no previous point, line width 1.0, 64 slots
`default_nettype none
module trail_ribbon_point_generator_unit
  import trpg_pkg::*;
#(
  parameter int RING_DEPTH = RingDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // slave side
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, pos_z, fwd_x, fwd_y, fwd_z (32 each), view_x, view_y, view_z (16 each)
  input  wire logic [239:0] s_axis_tdata,
  // master side
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status(2), top_x, top_y, top_z, bottom_x, bottom_y, bottom_z (32 each),
  // slot_index(6), oldest_index(6), trail_count(6), zero pad(4)
  output logic [215:0]      m_axis_tdata,
  // register writes
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  localparam int SW = $clog2(RING_DEPTH);
  localparam int CW = SW + 1;

  // control state
  state_e         state_q, state_d;
  logic [2:0]     idx_q, idx_d;
  logic           have_q, have_d;
  logic [SW-1:0]  ins_q, ins_d;
  logic [SW-1:0]  old_q, old_d;
  logic [30:0]    lw_q, lw_d;
  logic [6:0]     re_q, re_d;
  logic           ovld_q, ovld_d;

  // datapath registers
  logic signed [31:0] p_q[3], p_d[3];
  logic signed [31:0] f_q[3], f_d[3];
  logic signed [15:0] v_q[3], v_d[3];
  logic signed [17:0] n_q[3], n_d[3];   // normalized motion, later the unit offset
  logic signed [21:0] c_q[3], c_d[3];
  logic signed [32:0] pp_q[3], pp_d[3];
  logic signed [31:0] t_q[3], t_d[3];
  logic signed [31:0] b_q[3], b_d[3];
  logic signed [31:0] lt_q[3], lt_d[3];
  logic signed [31:0] lb_q[3], lb_d[3];
  logic [63:0]        s_q, s_d;
  logic signed [35:0] dot_q, dot_d;
  logic signed [35:0] cacc_q, cacc_d;
  logic [33:0]        d2_q, d2_d;
  logic               small_q, small_d;
  logic [31:0]        inv_q, inv_d;
  status_e            st_q, st_d;

  // shared multiplier
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod_d, prod_q;

  // result register
  status_e            o_st_q, o_st_d;
  logic signed [31:0] o_t_q[3], o_t_d[3];
  logic signed [31:0] o_b_q[3], o_b_d[3];
  logic [5:0]         o_slot_q, o_slot_d;
  logic [5:0]         o_old_q, o_old_d;
  logic [5:0]         o_cnt_q, o_cnt_d;

  logic               rs_start;
  logic               rs_done;
  logic [31:0]        rs_root;
  logic [CW-1:0]      ring_m;
  logic signed [35:0] cdiff;
  logic signed [32:0] dd;
  logic signed [32:0] halfd;
  logic [SW-1:0]      ins_nx;
  logic [CW-1:0]      cnt_w;
  logic [1:0]         i2;

  trpg_rsqrt u_rsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(rs_start),
    .s_i    (s_q),
    .done_o (rs_done),
    .root_o (rs_root)
  );

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (x < -34'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [SW-1:0] nxt(input logic [SW-1:0] s, input logic [CW-1:0] m);
    logic [CW-1:0] n;
    n = {1'b0, s} + CW'(1);
    return (n >= m) ? '0 : n[SW-1:0];
  endfunction

  // slots in use, clamped to 2..RING_DEPTH
  always_comb begin
    if (re_q < 7'd2) ring_m = CW'(2);
    else if (int'(re_q) > RING_DEPTH) ring_m = CW'(RING_DEPTH);
    else ring_m = CW'(re_q);
  end

  assign i2    = idx_q[1:0];
  assign cdiff = cacc_q - $signed(prod_q[35:0]);
  assign dd    = 33'(lt_q[i2]) - 33'(t_q[i2]);

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      S_SQ_M: begin
        op_a = 33'(f_q[i2]);
        op_b = 33'(f_q[i2]);
      end
      S_N_M: begin
        op_a = $signed({1'b0, inv_q});
        op_b = 33'(f_q[i2]);
      end
      S_DOT_M: begin
        op_a = 33'(v_q[i2]);
        op_b = 33'(n_q[i2]);
      end
      S_CR_M: begin
        // n x view, two products per component
        case (idx_q)
          3'd0: begin op_a = 33'(n_q[1]); op_b = 33'(v_q[2]); end
          3'd1: begin op_a = 33'(n_q[2]); op_b = 33'(v_q[1]); end
          3'd2: begin op_a = 33'(n_q[2]); op_b = 33'(v_q[0]); end
          3'd3: begin op_a = 33'(n_q[0]); op_b = 33'(v_q[2]); end
          3'd4: begin op_a = 33'(n_q[0]); op_b = 33'(v_q[1]); end
          default: begin op_a = 33'(n_q[1]); op_b = 33'(v_q[0]); end
        endcase
      end
      S_S2_M: begin
        op_a = 33'(c_q[i2]);
        op_b = 33'(c_q[i2]);
      end
      S_U_M: begin
        op_a = $signed({1'b0, inv_q});
        op_b = 33'(c_q[i2]);
      end
      S_PP_M: begin
        op_a = $signed({2'b00, lw_q});
        op_b = 33'(n_q[i2]);
      end
      S_CL_M: begin
        op_a = 33'($signed(dd[17:0]));
        op_b = 33'($signed(dd[17:0]));
      end
      default: ;
    endcase
  end

  assign prod_d = 66'(op_a) * 66'(op_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      have_q  <= 1'b0;
      ins_q   <= '0;
      old_q   <= '0;
      lw_q    <= LINE_WIDTH_RST;
      re_q    <= RING_ENTRIES_RST;
      ovld_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lt_q[i] <= '0;
        lb_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      have_q  <= have_d;
      ins_q   <= ins_d;
      old_q   <= old_d;
      lw_q    <= lw_d;
      re_q    <= re_d;
      ovld_q  <= ovld_d;
      lt_q    <= lt_d;
      lb_q    <= lb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    f_q      <= f_d;
    v_q      <= v_d;
    n_q      <= n_d;
    c_q      <= c_d;
    pp_q     <= pp_d;
    t_q      <= t_d;
    b_q      <= b_d;
    s_q      <= s_d;
    dot_q    <= dot_d;
    cacc_q   <= cacc_d;
    d2_q     <= d2_d;
    small_q  <= small_d;
    inv_q    <= inv_d;
    st_q     <= st_d;
    prod_q   <= prod_d;
    o_st_q   <= o_st_d;
    o_t_q    <= o_t_d;
    o_b_q    <= o_b_d;
    o_slot_q <= o_slot_d;
    o_old_q  <= o_old_d;
    o_cnt_q  <= o_cnt_d;
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    have_d   = have_q;
    ins_d    = ins_q;
    old_d    = old_q;
    lw_d     = lw_q;
    re_d     = re_q;
    ovld_d   = ovld_q && !m_axis_tready;
    p_d      = p_q;
    f_d      = f_q;
    v_d      = v_q;
    n_d      = n_q;
    c_d      = c_q;
    pp_d     = pp_q;
    t_d      = t_q;
    b_d      = b_q;
    lt_d     = lt_q;
    lb_d     = lb_q;
    s_d      = s_q;
    dot_d    = dot_q;
    cacc_d   = cacc_q;
    d2_d     = d2_q;
    small_d  = small_q;
    inv_d    = inv_q;
    st_d     = st_q;
    o_st_d   = o_st_q;
    o_t_d    = o_t_q;
    o_b_d    = o_b_q;
    o_slot_d = o_slot_q;
    o_old_d  = o_old_q;
    o_cnt_d  = o_cnt_q;
    rs_start = 1'b0;
    halfd    = '0;
    ins_nx   = nxt(ins_q, ring_m);
    cnt_w    = '0;

    // register writes, taken only while idle
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LINE_WIDTH: lw_d = cfg_data_i[30:0];
        CFG_RING_ENTRIES: begin
          re_d  = cfg_data_i[6:0];
          ins_d = '0;
          old_d = '0;
        end
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          p_d[0] = s_axis_tdata[31:0];
          p_d[1] = s_axis_tdata[63:32];
          p_d[2] = s_axis_tdata[95:64];
          f_d[0] = s_axis_tdata[127:96];
          f_d[1] = s_axis_tdata[159:128];
          f_d[2] = s_axis_tdata[191:160];
          v_d[0] = s_axis_tdata[207:192];
          v_d[1] = s_axis_tdata[223:208];
          v_d[2] = s_axis_tdata[239:224];
          s_d     = '0;
          idx_d   = '0;
          state_d = S_SQ_M;
        end
      end
      S_SQ_M: state_d = S_SQ_W;
      S_SQ_W: begin
        s_d = s_q + prod_q[63:0];
        if (idx_q == 3'd2) state_d = S_CHK_S;
        else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_SQ_M;
        end
      end
      S_CHK_S: begin
        if (s_q < FWD_MIN_SQ) begin
          st_d    = ST_NOPT;
          state_d = S_FIN;
        end else begin
          rs_start = 1'b1;
          state_d  = S_R1;
        end
      end
      S_R1: begin
        if (rs_done) begin
          inv_d   = rs_root;
          idx_d   = '0;
          state_d = S_N_M;
        end
      end
      S_N_M: state_d = S_N_W;
      S_N_W: begin
        n_d[i2] = prod_q[33:16];
        if (idx_q == 3'd2) begin
          idx_d   = '0;
          dot_d   = '0;
          state_d = S_DOT_M;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_N_M;
        end
      end
      S_DOT_M: state_d = S_DOT_W;
      S_DOT_W: begin
        dot_d = dot_q + $signed(prod_q[35:0]);
        if (idx_q == 3'd2) state_d = S_CHK_DOT;
        else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_DOT_M;
        end
      end
      S_CHK_DOT: begin
        idx_d = '0;
        if (dot_q < DOT_PAR_MIN) state_d = S_CR_M;
        else if (have_q) state_d = S_PAR;
        else begin
          st_d    = ST_NOPT;
          state_d = S_FIN;
        end
      end
      S_CR_M: state_d = S_CR_W;
      S_CR_W: begin
        if (!idx_q[0]) cacc_d = $signed(prod_q[35:0]);
        else c_d[idx_q[2:1]] = cdiff[35:14];
        if (idx_q == 3'd5) begin
          idx_d   = '0;
          s_d     = '0;
          state_d = S_S2_M;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_CR_M;
        end
      end
      S_S2_M: state_d = S_S2_W;
      S_S2_W: begin
        s_d = s_q + prod_q[63:0];
        if (idx_q == 3'd2) state_d = S_R2_GO;
        else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_S2_M;
        end
      end
      S_R2_GO: begin
        rs_start = 1'b1;
        state_d  = S_R2;
      end
      S_R2: begin
        if (rs_done) begin
          inv_d   = rs_root;
          idx_d   = '0;
          state_d = S_U_M;
        end
      end
      S_U_M: state_d = S_U_W;
      S_U_W: begin
        n_d[i2] = prod_q[33:16];
        if (idx_q == 3'd2) begin
          idx_d   = '0;
          state_d = S_PP_M;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_U_M;
        end
      end
      S_PP_M: state_d = S_PP_W;
      S_PP_W: begin
        pp_d[i2] = prod_q[48:16];
        if (idx_q == 3'd2) state_d = S_TB;
        else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_PP_M;
        end
      end
      S_PAR: begin
        // reuse half the previous top-minus-bottom
        for (int i = 0; i < 3; i++) begin
          halfd = 33'(lt_q[i]) - 33'(lb_q[i]);
          pp_d[i] = halfd >>> 1;
        end
        state_d = S_TB;
      end
      S_TB: begin
        for (int i = 0; i < 3; i++) begin
          t_d[i] = sat32(34'(p_q[i]) + 34'(pp_q[i]));
          b_d[i] = sat32(34'(p_q[i]) - 34'(pp_q[i]));
        end
        idx_d   = '0;
        d2_d    = '0;
        small_d = 1'b1;
        if (have_q) state_d = S_CL_M;
        else begin
          st_d    = ST_APPEND;
          state_d = S_FIN;
        end
      end
      S_CL_M: begin
        if (dd >= 33'sd65536 || dd <= -33'sd65536) small_d = 1'b0;
        state_d = S_CL_W;
      end
      S_CL_W: begin
        d2_d = d2_q + prod_q[33:0];
        if (idx_q == 3'd2) state_d = S_CL_CHK;
        else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_CL_M;
        end
      end
      S_CL_CHK: begin
        st_d    = (small_q && d2_q < CLOSE_SQ) ? ST_CLOSE : ST_APPEND;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!ovld_q || m_axis_tready) begin
          o_slot_d = 6'(16'(ins_q));
          for (int i = 0; i < 3; i++) begin
            o_t_d[i] = '0;
            o_b_d[i] = '0;
          end
          case (st_q)
            ST_APPEND: begin
              lt_d   = t_q;
              lb_d   = b_q;
              o_t_d  = t_q;
              o_b_d  = b_q;
              have_d = 1'b1;
              ins_d  = ins_nx;
              if (ins_nx == old_q) old_d = nxt(old_q, ring_m);
            end
            ST_NOPT: begin
              if (ins_q != old_q) old_d = nxt(old_q, ring_m);
            end
            default: ;
          endcase
          if (old_d < ins_d) cnt_w = CW'({1'b0, ins_d} - {1'b0, old_d});
          else if (old_d > ins_d) cnt_w = ring_m - CW'({1'b0, old_d}) + CW'({1'b0, ins_d});
          else cnt_w = '0;
          o_st_d  = st_q;
          o_old_d = 6'(16'(old_d));
          o_cnt_d = 6'(16'(cnt_w));
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {4'b0000, o_cnt_q, o_old_q, o_slot_q,
                          o_b_q[2], o_b_q[1], o_b_q[0],
                          o_t_q[2], o_t_q[1], o_t_q[0], o_st_q};

endmodule
`default_nettype wire

/* sv/trpg_rsqrt.sv */
`default_nettype none
// floor(2^32 / sqrt(s)): restoring divide of 2^64 by s, then digit-by-digit root
module trpg_rsqrt
  import trpg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] s_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  rsq_state_e  state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] den_q, den_d;
  logic [63:0] rem_q, rem_d;
  logic [65:0] rad_q, rad_d;
  logic [35:0] srem_q, srem_d;
  logic [32:0] sroot_q, sroot_d;
  logic [31:0] res_q, res_d;

  logic [64:0] dshift;
  logic [35:0] sshift;
  logic [35:0] trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q   <= den_d;
    rem_q   <= rem_d;
    rad_q   <= rad_d;
    srem_q  <= srem_d;
    sroot_q <= sroot_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    den_d   = den_q;
    rem_d   = rem_q;
    rad_d   = rad_q;
    srem_d  = srem_q;
    sroot_d = sroot_q;
    res_d   = res_q;
    dshift  = {rem_q, (cnt_q == 7'd64)};
    sshift  = {srem_q[33:0], rad_q[65:64]};
    trial   = {1'b0, sroot_q, 2'b01};
    done_o  = 1'b0;
    case (state_q)
      RS_IDLE: begin
        if (start_i) begin
          if (s_i == '0) begin
            res_d   = '0;
            state_d = RS_DONE;
          end else begin
            den_d   = s_i;
            rem_d   = '0;
            rad_d   = '0;
            cnt_d   = 7'd64;
            state_d = RS_DIV;
          end
        end
      end
      RS_DIV: begin
        // quotient bits shift into rad
        if (dshift >= {1'b0, den_q}) begin
          rem_d = 64'(dshift - {1'b0, den_q});
          rad_d = {rad_q[64:0], 1'b1};
        end else begin
          rem_d = dshift[63:0];
          rad_d = {rad_q[64:0], 1'b0};
        end
        if (cnt_q == '0) begin
          srem_d  = '0;
          sroot_d = '0;
          cnt_d   = 7'd32;
          state_d = RS_SQRT;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      RS_SQRT: begin
        rad_d = {rad_q[63:0], 2'b00};
        if (sshift >= trial) begin
          srem_d  = sshift - trial;
          sroot_d = {sroot_q[31:0], 1'b1};
        end else begin
          srem_d  = sshift;
          sroot_d = {sroot_q[31:0], 1'b0};
        end
        if (cnt_q == '0) begin
          res_d   = sroot_d[32] ? 32'hFFFF_FFFF : sroot_d[31:0];
          state_d = RS_DONE;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      RS_DONE: begin
        done_o  = 1'b1;
        state_d = RS_IDLE;
      end
      default: state_d = RS_IDLE;
    endcase
  end

  assign root_o = res_q;

endmodule
`default_nettype wire

/* sv/trpg_checker.sv */
`default_nettype none
module trpg_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [215:0] m_axis_tdata
);

  // the sequencer is busy right after it takes a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accept");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status code");

  // no point pair unless appended
  a_points_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[193:2] == '0)
    else $error("points present without append");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

endmodule

bind trail_ribbon_point_generator_unit trpg_checker u_trpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
